// ===== sv/pra_pkg.sv =====
// shared constants, codes, command/status structs and encoder functions of the allocator
`default_nettype none
package pra_pkg;

    localparam int RESOURCES = 9;
    localparam int CLIENTS   = 16;

    localparam int RIDX_W = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int CIDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

    localparam int MODE_W    = 2;
    localparam int CLIENT_W  = 4;
    localparam int TICKS_W   = 16;
    localparam int RES_W     = 4;
    localparam int GRANTED_W = 4;
    localparam int STATUS_W  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_REQUEST = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_TICK    = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED     = 3'd0,
        ST_BLOCKED     = 3'd1,
        ST_TIMED_OUT   = 3'd2,
        ST_FREED       = 3'd3,
        ST_BAD_RELEASE = 3'd4,
        ST_DUP_WAIT    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic do_req;
        logic do_rel;
        logic tick_start;
        logic walk_step;
        logic emit_one;
    } pra_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic walk_last;
        logic mask_any;
        logic mask_last;
    } pra_stat_t;

    // index of lowest clear bit in the busy map
    function automatic logic [RIDX_W-1:0] low_free_res(input logic [RESOURCES-1:0] busy);
        logic [RIDX_W-1:0] idx;
        idx = '0;
        for (int i = RESOURCES - 1; i >= 0; i--) begin
            if (!busy[i]) begin
                idx = RIDX_W'(i);
            end
        end
        return idx;
    endfunction

    // index of lowest set bit in a per-client vector
    function automatic logic [CIDX_W-1:0] low_client(input logic [CLIENTS-1:0] vec);
        logic [CIDX_W-1:0] idx;
        idx = '0;
        for (int i = CLIENTS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = CIDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== sv/pra_datapath.sv =====
// allocator datapath: busy map, wait flags, tick counters, timeout mask, output register
`default_nettype none
module pra_datapath
    import pra_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pra_cmd_t             cmd,
    output pra_stat_t                 stat,
    input  wire logic [CLIENT_W-1:0]  client,
    input  wire logic [TICKS_W-1:0]   timeout_ticks,
    input  wire logic [RES_W-1:0]     resource,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [CLIENT_W-1:0]       client_out,
    output logic [GRANTED_W-1:0]      granted,
    output logic [STATUS_W-1:0]       status,
    output logic                      last
);

    logic [RESOURCES-1:0] busy_reg, busy_next;
    logic [CLIENTS-1:0]   wait_reg, wait_next;
    logic [CLIENTS-1:0]   mask_reg, mask_next;
    logic [TICKS_W-1:0]   ticks_reg [CLIENTS];
    logic [CIDX_W-1:0]    idx_reg, idx_next;

    logic                 out_valid_reg, out_valid_next;
    logic [CLIENT_W-1:0]  client_out_reg, client_out_next;
    logic [GRANTED_W-1:0] granted_reg, granted_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 last_reg, last_next;

    logic [CIDX_W-1:0]    req_idx;
    logic                 req_in_range;
    logic                 res_any_free;
    logic [RIDX_W-1:0]    res_free_idx;
    logic                 rel_ok;
    logic [RIDX_W-1:0]    rel_idx;
    logic                 any_waiter;
    logic [CIDX_W-1:0]    waiter_idx;
    logic [TICKS_W-1:0]   walk_ticks;
    logic                 walk_waiting;
    logic                 walk_expire;
    logic [CIDX_W-1:0]    mask_idx;
    logic [CLIENTS-1:0]   mask_rest;
    logic                 load;

    // request and release decode
    assign req_idx      = CIDX_W'(client);
    assign req_in_range = 32'(client) < CLIENTS;
    assign res_any_free = ~&busy_reg;
    assign res_free_idx = low_free_res(busy_reg);
    assign rel_idx      = RIDX_W'(resource - RES_W'(1));
    assign rel_ok       = (resource != '0) && (32'(resource) <= RESOURCES) && busy_reg[rel_idx];
    assign any_waiter   = |wait_reg;
    assign waiter_idx   = low_client(wait_reg);

    // tick walk over one client per cycle
    assign walk_ticks   = ticks_reg[idx_reg];
    assign walk_waiting = wait_reg[idx_reg];
    assign walk_expire  = walk_waiting && (walk_ticks <= TICKS_W'(1));

    // timed-out clients pending report
    assign mask_idx  = low_client(mask_reg);
    assign mask_rest = mask_reg & ~(CLIENTS'(1) << mask_idx);

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.walk_last = idx_reg == CIDX_W'(CLIENTS - 1);
    assign stat.mask_any  = |mask_reg;
    assign stat.mask_last = mask_rest == '0;

    // next state of allocator state and output register
    always_comb
    begin
        busy_next       = busy_reg;
        wait_next       = wait_reg;
        mask_next       = mask_reg;
        idx_next        = idx_reg;
        load            = 1'b0;
        client_out_next = client_out_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        last_next       = last_reg;

        if (cmd.do_req && req_in_range) begin
            load            = 1'b1;
            client_out_next = client;
            granted_next    = '0;
            last_next       = 1'b1;
            if (wait_reg[req_idx]) begin
                status_next = ST_DUP_WAIT;
            end
            else if (res_any_free) begin
                busy_next[res_free_idx] = 1'b1;
                granted_next = GRANTED_W'(32'(res_free_idx) + 1);
                status_next  = ST_GRANTED;
            end
            else if (timeout_ticks == '0) begin
                status_next = ST_TIMED_OUT;
            end
            else begin
                wait_next[req_idx] = 1'b1;
                status_next = ST_BLOCKED;
            end
        end

        if (cmd.do_rel) begin
            load            = 1'b1;
            client_out_next = '0;
            granted_next    = '0;
            last_next       = 1'b1;
            if (!rel_ok) begin
                status_next = ST_BAD_RELEASE;
            end
            else if (any_waiter) begin
                wait_next[waiter_idx] = 1'b0;
                client_out_next = CLIENT_W'(waiter_idx);
                granted_next    = GRANTED_W'(resource);
                status_next     = ST_GRANTED;
            end
            else begin
                busy_next[rel_idx] = 1'b0;
                status_next = ST_FREED;
            end
        end

        if (cmd.tick_start) begin
            idx_next  = '0;
            mask_next = '0;
        end

        if (cmd.walk_step) begin
            idx_next = idx_reg + CIDX_W'(1);
            if (walk_expire) begin
                wait_next[idx_reg] = 1'b0;
                mask_next[idx_reg] = 1'b1;
            end
        end

        if (cmd.emit_one) begin
            load            = 1'b1;
            mask_next       = mask_rest;
            client_out_next = CLIENT_W'(mask_idx);
            granted_next    = '0;
            status_next     = ST_TIMED_OUT;
            last_next       = mask_rest == '0;
        end

        if (load) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= '0;
            wait_reg      <= '0;
            mask_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            busy_reg      <= busy_next;
            wait_reg      <= wait_next;
            mask_reg      <= mask_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        client_out_reg <= client_out_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
        if (cmd.do_req && req_in_range && !wait_reg[req_idx] && !res_any_free) begin
            ticks_reg[req_idx] <= timeout_ticks;
        end
        if (cmd.walk_step && walk_waiting && (walk_ticks != '0)) begin
            ticks_reg[idx_reg] <= walk_ticks - TICKS_W'(1);
        end
    end

    assign out_valid  = out_valid_reg;
    assign client_out = client_out_reg;
    assign granted    = granted_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire

// ===== sv/pra_controller.sv =====
// allocator controller: sequences accept, tick walk and timeout reporting
`default_nettype none
module pra_controller
    import pra_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [MODE_W-1:0] mode,
    input  wire pra_stat_t         stat,
    output pra_cmd_t               cmd
);

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free) begin
                    unique case (mode)
                        MODE_REQUEST: cmd.do_req = 1'b1;
                        MODE_RELEASE: cmd.do_rel = 1'b1;
                        MODE_TICK:
                        begin
                            cmd.tick_start = 1'b1;
                            state_next     = S_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!stat.mask_any) begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free) begin
                    cmd.emit_one = 1'b1;
                    if (stat.mask_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/priority_resource_allocator_timeout.sv =====
// Request and release: the result is registered at the accepting edge;
// while results are taken at once, one such transaction is accepted every cycle.
// A tick walks the counters of all CLIENTS clients (16 here) one per cycle, then enters the report state
// and reports timed-out clients one per cycle while the output is taken;
// no new input is accepted until the tick has reported its last timed-out client.
// Reset (asynchronous, active low): all resources free, no client waiting, output empty.
`default_nettype none
module priority_resource_allocator_timeout
    import pra_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [MODE_W-1:0]    mode,
    input  wire logic [CLIENT_W-1:0]  client,
    input  wire logic [TICKS_W-1:0]   timeout_ticks,
    input  wire logic [RES_W-1:0]     resource,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [CLIENT_W-1:0]       client_out,
    output logic [GRANTED_W-1:0]      granted,
    output logic [STATUS_W-1:0]       status,
    output logic                      last
);

    pra_cmd_t  cmd;
    pra_stat_t stat;

    // sequencing
    pra_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    // allocator state and results
    pra_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .client        (client),
        .timeout_ticks (timeout_ticks),
        .resource      (resource),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .client_out    (client_out),
        .granted       (granted),
        .status        (status),
        .last          (last)
    );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for the priority resource allocator with tick timeouts
`timescale 1ns / 1ps
module tb_top;
    import pra_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 430;
    localparam int HOLD_AFTER   = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [MODE_W-1:0]   op;
        logic [CLIENT_W-1:0] who;
        logic [TICKS_W-1:0]  wait_ticks;
        logic [RES_W-1:0]    res;
        int                  gap;
    } alloc_item_t;

    typedef struct {
        logic [CLIENT_W-1:0]  who;
        logic [GRANTED_W-1:0] res;
        logic [STATUS_W-1:0]  st;
        logic                 fin;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [MODE_W-1:0]    mode = '0;
    logic [CLIENT_W-1:0]  client = '0;
    logic [TICKS_W-1:0]   timeout_ticks = '0;
    logic [RES_W-1:0]     resource = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CLIENT_W-1:0]  client_out;
    logic [GRANTED_W-1:0] granted;
    logic [STATUS_W-1:0]  status;
    logic                 last;

    // allocator shadow state
    logic [RESOURCES-1:0] busy_res = '0;
    logic [CLIENTS-1:0]   waiting = '0;
    logic [TICKS_W-1:0]   ticks_left [CLIENTS];

    alloc_item_t pending_q [$];
    outcome_t    outcome_q [$];
    int          errors = 0;
    int          taken_cnt = 0;
    int          result_cnt = 0;
    int          cycles = 0;
    logic        hold_on = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_cnt = 0;
    logic        have_pending = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          gen_cnt = 0;
    alloc_item_t next_item;

    priority_resource_allocator_timeout DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .client       (client),
        .timeout_ticks(timeout_ticks),
        .resource     (resource),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .client_out   (client_out),
        .granted      (granted),
        .status       (status),
        .last         (last)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        begin
            errors++;
            $display("mismatch %s: expected %0d got %0d (result %0d)", what, exp_v, got_v,
                     result_cnt);
        end
    endtask

    task automatic push_outcome(input int who, input int res, input status_t st,
                                input logic fin);
        outcome_t o;
        begin
            o.who = CLIENT_W'(who);
            o.res = GRANTED_W'(res);
            o.st  = st;
            o.fin = fin;
            outcome_q.push_back(o);
        end
    endtask

    // shadow allocator: update state and queue the outcomes of one transaction
    task automatic allocate_step(input logic [MODE_W-1:0] op, input logic [CLIENT_W-1:0] who,
                                 input logic [TICKS_W-1:0] wait_ticks,
                                 input logic [RES_W-1:0] res);
        int                 found;
        int                 hi;
        logic [CLIENTS-1:0] expired;
        begin
            found = -1;
            hi = -1;
            expired = '0;
            if (op == MODE_REQUEST)
            begin
                if (int'(who) < CLIENTS)
                begin
                    if (waiting[who])
                        push_outcome(who, 0, ST_DUP_WAIT, 1'b1);
                    else
                    begin
                        for (int k = RESOURCES - 1; k >= 0; k--)
                            if (!busy_res[k])
                                found = k;
                        if (found >= 0)
                        begin
                            busy_res[found] = 1'b1;
                            push_outcome(who, found + 1, ST_GRANTED, 1'b1);
                        end
                        else if (wait_ticks == 0)
                            push_outcome(who, 0, ST_TIMED_OUT, 1'b1);
                        else
                        begin
                            waiting[who] = 1'b1;
                            ticks_left[who] = wait_ticks;
                            push_outcome(who, 0, ST_BLOCKED, 1'b1);
                        end
                    end
                end
            end
            else if (op == MODE_RELEASE)
            begin
                if (res == 0 || int'(res) > RESOURCES || !busy_res[res - 1])
                    push_outcome(0, 0, ST_BAD_RELEASE, 1'b1);
                else
                begin
                    for (int k = CLIENTS - 1; k >= 0; k--)
                        if (waiting[k])
                            found = k;
                    if (found >= 0)
                    begin
                        // hand-off: resource stays busy
                        waiting[found] = 1'b0;
                        ticks_left[found] = '0;
                        push_outcome(found, res, ST_GRANTED, 1'b1);
                    end
                    else
                    begin
                        busy_res[res - 1] = 1'b0;
                        push_outcome(0, 0, ST_FREED, 1'b1);
                    end
                end
            end
            else if (op == MODE_TICK)
            begin
                for (int k = 0; k < CLIENTS; k++)
                begin
                    if (waiting[k])
                    begin
                        if (ticks_left[k] > 0)
                            ticks_left[k] = ticks_left[k] - 1'b1;
                        if (ticks_left[k] == 0)
                        begin
                            waiting[k] = 1'b0;
                            expired[k] = 1'b1;
                            hi = k;
                        end
                    end
                end
                for (int k = 0; k < CLIENTS; k++)
                    if (expired[k])
                        push_outcome(k, 0, ST_TIMED_OUT, k == hi);
            end
        end
    endtask

    task automatic add_item(input logic [MODE_W-1:0] op, input int who, input int wait_ticks,
                            input int res);
        alloc_item_t it;
        begin
            it.op = op;
            it.who = CLIENT_W'(who);
            it.wait_ticks = TICKS_W'(wait_ticks);
            it.res = RES_W'(res);
            // alternate stretches of back-to-back items with random gaps
            it.gap = (((gen_cnt / 50) % 3) == 1) ? 0 : $urandom_range(9);
            gen_cnt++;
            pending_q.push_back(it);
        end
    endtask

    // driver: offer queued transactions, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            have_pending = 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                allocate_step(mode, client, timeout_ticks, resource);
                taken_cnt <= taken_cnt + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (!have_pending && pending_q.size() != 0)
                begin
                    next_item = pending_q.pop_front();
                    have_pending = 1'b1;
                    gap_left = next_item.gap;
                end
                if (have_pending && gap_left == 0)
                begin
                    mode <= next_item.op;
                    client <= next_item.who;
                    timeout_ticks <= next_item.wait_ticks;
                    resource <= next_item.res;
                    in_valid <= 1'b1;
                    have_pending = 1'b0;
                end
                else
                begin
                    if (have_pending)
                        gap_left--;
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random output stalls, compare each transaction with the oldest outcome
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("unexpected result, client", -1, client_out);
                else
                begin
                    o = outcome_q.pop_front();
                    if (client_out !== o.who)
                        report_mismatch("client_out", o.who, client_out);
                    if (granted !== o.res)
                        report_mismatch("granted", o.res, granted);
                    if (status !== o.st)
                        report_mismatch("status", o.st, status);
                    if (last !== o.fin)
                        report_mismatch("last", o.fin, last);
                end
                result_cnt++;
                stall_left = (((result_cnt / 40) % 3) == 2) ? 0 : $urandom_range(9);
            end
            else if (stall_left > 0)
                stall_left--;
            out_ready <= !hold_on && stall_left == 0;
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_on <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt <= 0;
        end
        else if (!hold_done)
        begin
            if (!hold_on && taken_cnt >= HOLD_AFTER)
            begin
                hold_on <= 1'b1;
                hold_cnt <= HOLD_CYCLES;
            end
            else if (hold_on)
            begin
                if (hold_cnt == 0)
                begin
                    hold_on <= 1'b0;
                    hold_done <= 1'b1;
                end
                else
                    hold_cnt <= hold_cnt - 1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int pick;
        int n;
        int who;
        int res;
        int wt;
        logic [RESOURCES-1:0] busy_now;
        for (int k = 0; k < CLIENTS; k++)
            ticks_left[k] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // fill the pool, then exercise every outcome
        for (int k = 0; k < RESOURCES; k++)
            add_item(MODE_REQUEST, k, 16'hFFFF, 0);
        add_item(MODE_REQUEST, 15, 0, 0);         // no resource, zero timeout
        add_item(MODE_REQUEST, 12, 2, 0);         // blocks
        add_item(MODE_REQUEST, 12, 7, 0);         // already waiting
        add_item(MODE_REQUEST, 3, 16'hFFFF, 0);   // blocks with longest wait
        add_item(MODE_TICK, 10, 16'h5A5A, 9);     // nobody runs out
        add_item(MODE_RELEASE, 0, 0, 5);          // handed to client 3
        add_item(MODE_TICK, 0, 0, 0);             // client 12 runs out
        add_item(MODE_REQUEST, 1, 1, 0);
        add_item(MODE_REQUEST, 2, 1, 0);
        add_item(MODE_TICK, 0, 0, 0);             // two clients run out together
        add_item(MODE_RELEASE, 0, 0, 0);          // resource zero
        add_item(MODE_RELEASE, 0, 0, 10);         // above the pool
        add_item(MODE_RELEASE, 15, 16'hFFFF, 15);
        add_item(MODE_RELEASE, 0, 0, 9);          // freed
        add_item(MODE_RELEASE, 0, 0, 9);          // already free
        add_item(MODE_UNUSED, 15, 16'hFFFF, 15);  // ignored

        // random requests, releases (mostly legal releases of busy resources), ticks and unused modes
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            while (pending_q.size() >= 2)
                @(negedge clk);
            pick = $urandom_range(99);
            who = $urandom_range(CLIENTS - 1);
            if (pick < 45)
            begin
                pick = $urandom_range(9);
                if (pick == 0)
                    wt = 0;
                else if (pick == 1)
                    wt = $urandom_range(16'hFFFF);
                else if (pick == 2)
                    wt = 16'hFFFF - $urandom_range(3);
                else
                    wt = $urandom_range(6, 1);
                add_item(MODE_REQUEST, who, wt, $urandom_range(15));
                n++;
            end
            else if (pick < 75)
            begin
                busy_now = busy_res;
                res = $urandom_range(15);
                if (busy_now != 0 && $urandom_range(9) < 8)
                begin
                    res = $urandom_range(RESOURCES, 1);
                    while (!busy_now[res - 1])
                        res = $urandom_range(RESOURCES, 1);
                end
                add_item(MODE_RELEASE, who, $urandom_range(16'hFFFF), res);
                n++;
            end
            else if (pick < 95)
            begin
                add_item(MODE_TICK, who, $urandom_range(16'hFFFF), $urandom_range(15));
                n++;
            end
            else
                add_item(MODE_UNUSED, who, $urandom_range(16'hFFFF), $urandom_range(15));
        end

        // drain
        while (pending_q.size() != 0 || have_pending || in_valid || outcome_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
